// File: hdl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg: shared types, codes and microcode for the Bezier evaluator
// Holds field widths, the control word and status layouts, and the
// read-only microprogram that drives the interpolation datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_W        = 32;
  localparam int T_W            = 17;
  localparam int CNT_W          = 5;
  localparam int IDX_W          = 4;
  localparam int FRAC_W         = 16;
  localparam int PROD_W         = COORD_W + T_W + 1;
  localparam int STEP_W         = 4;

  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  // opcodes of an input beat
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // jump conditions
  localparam logic [2:0] C_NONE        = 3'd0;
  localparam logic [2:0] C_ALWAYS      = 3'd1;
  localparam logic [2:0] C_START       = 3'd2;
  localparam logic [2:0] C_LEN_ZERO    = 3'd3;
  localparam logic [2:0] C_LEN_ONE     = 3'd4;
  localparam logic [2:0] C_MORE_PAIRS  = 3'd5;
  localparam logic [2:0] C_MORE_LEVELS = 3'd6;
  localparam logic [2:0] C_OUT_FREE    = 3'd7;

  // read address selects
  localparam logic [1:0] ADDR_ZERO = 2'd0;
  localparam logic [1:0] ADDR_IDX1 = 2'd1;
  localparam logic [1:0] ADDR_IDX2 = 2'd2;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_CHK0  = 4'd1;
  localparam logic [STEP_W-1:0] S_CHK1  = 4'd2;
  localparam logic [STEP_W-1:0] S_LVL0  = 4'd3;
  localparam logic [STEP_W-1:0] S_LVL1  = 4'd4;
  localparam logic [STEP_W-1:0] S_MUL   = 4'd5;
  localparam logic [STEP_W-1:0] S_WRITE = 4'd6;
  localparam logic [STEP_W-1:0] S_LEND  = 4'd7;
  localparam logic [STEP_W-1:0] S_FIN   = 4'd8;
  localparam logic [STEP_W-1:0] S_OUT   = 4'd9;
  localparam logic [STEP_W-1:0] S_ZERO  = 4'd10;

  typedef struct packed {
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic              hold;
    logic              rd_en;
    logic [1:0]        addr_sel;
    logic              a_ld;
    logic              mul_en;
    logic              wr_en;
    logic              idx_inc;
    logic              lvl_dec;
    logic              out_ld;
    logic              out_zero;
  } cw_t;

  typedef struct packed {
    logic start;
    logic out_free;
    logic len_zero;
    logic len_one;
    logic more_pairs;
    logic more_levels;
  } stat_t;

  // Microprogram. Next step is target when cond holds, else the same step
  // when hold is set, else the following step.
  function automatic cw_t ucode(input logic [STEP_W-1:0] step);
    cw_t w;
    w = '0;
    case (step)
      S_IDLE: begin
        w.cond   = C_START;
        w.target = S_CHK0;
        w.hold   = 1'b1;
      end
      S_CHK0: begin
        w.cond   = C_LEN_ZERO;
        w.target = S_ZERO;
      end
      S_CHK1: begin
        w.cond   = C_LEN_ONE;
        w.target = S_FIN;
      end
      S_LVL0: begin
        w.rd_en    = 1'b1;
        w.addr_sel = ADDR_ZERO;
      end
      S_LVL1: begin
        w.a_ld     = 1'b1;
        w.rd_en    = 1'b1;
        w.addr_sel = ADDR_IDX1;
      end
      S_MUL: begin
        w.mul_en = 1'b1;
        w.a_ld   = 1'b1;
      end
      S_WRITE: begin
        w.wr_en    = 1'b1;
        w.idx_inc  = 1'b1;
        w.rd_en    = 1'b1;
        w.addr_sel = ADDR_IDX2;
        w.cond     = C_MORE_PAIRS;
        w.target   = S_MUL;
      end
      S_LEND: begin
        w.lvl_dec = 1'b1;
        w.cond    = C_MORE_LEVELS;
        w.target  = S_LVL0;
      end
      S_FIN: begin
        w.rd_en    = 1'b1;
        w.addr_sel = ADDR_ZERO;
      end
      S_OUT: begin
        w.out_ld = 1'b1;
        w.cond   = C_OUT_FREE;
        w.target = S_IDLE;
        w.hold   = 1'b1;
      end
      S_ZERO: begin
        w.out_ld   = 1'b1;
        w.out_zero = 1'b1;
        w.cond     = C_OUT_FREE;
        w.target   = S_IDLE;
        w.hold     = 1'b1;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bezier_de_casteljau_eval.sv
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval: 2-D Bezier curve point by repeated lerp
// Control points load into a store by order position; a sample beat gives
// the curve point at parameter t in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): opcode 0 is a load beat that writes
//   point_x/point_y at point_index and gives no result; opcode 1 is a sample
//   beat that evaluates the curve at t (Q1.16, 65536 = 1.0, clamped there).
//   Output channel (out_valid / out_stall): one curve_x/curve_y beat per
//   sample. cfg_wen/cfg_wdata set point_count; write it only while idle.
//   Sequencing: a load is written in the cycle it is accepted. A sample
//   walks its levels through the one shared lerp unit: each interpolated
//   pair takes a multiply step, then a shift/add/saturate and write-back
//   step, and each level adds read setup and level-end steps.
//   One sample is in flight at a time; in_stall stays high until the
//   sequencer returns to idle, which it does as soon as its result lands in
//   the output register.
//   Receiver stall: the result register holds while out_stall is high; a
//   following sample is computed meanwhile and waits at its last step.
//   Reset: point_count clears to zero and the sequencer goes idle; the
//   point store is not cleared, so load every point in use before sampling.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_de_casteljau_eval #(
  parameter int MAX_POINTS = bdc_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic [bdc_pkg::IDX_W-1:0]          point_index,
  input  logic signed [bdc_pkg::COORD_W-1:0] point_x,
  input  logic signed [bdc_pkg::COORD_W-1:0] point_y,
  input  logic [bdc_pkg::T_W-1:0]            t,
  input  logic                               cfg_wen,
  input  logic [bdc_pkg::CNT_W-1:0]          cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bdc_pkg::COORD_W-1:0] curve_x,
  output logic signed [bdc_pkg::COORD_W-1:0] curve_y
);
  import bdc_pkg::*;

  cw_t   cw;
  stat_t stat;
  logic  idle;
  logic  in_fire;

  // take beats only at the idle step
  assign in_stall = !idle;
  assign in_fire  = in_valid && idle;

  bdc_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw),
    .idle (idle)
  );

  bdc_datapath #(
    .MaxPoints (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cw          (cw),
    .stat        (stat),
    .in_fire     (in_fire),
    .opcode      (opcode),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .t           (t),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .curve_x     (curve_x),
    .curve_y     (curve_y)
  );

endmodule

`default_nettype wire

// File: hdl/bdc_sequencer.sv
// ----------------------------------------------------------------------------
// bdc_sequencer: microcode step counter
// Fetches the control word for the current step and picks the next step
// from the word's jump condition and the datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  bdc_pkg::stat_t stat,
  output bdc_pkg::cw_t   cw,
  output logic           idle
);
  import bdc_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              taken;

  assign cw   = ucode(step);
  assign idle = (step == S_IDLE);

  always_comb begin
    case (cw.cond)
      C_NONE:        taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_START:       taken = stat.start;
      C_LEN_ZERO:    taken = stat.len_zero;
      C_LEN_ONE:     taken = stat.len_one;
      C_MORE_PAIRS:  taken = stat.more_pairs;
      C_MORE_LEVELS: taken = stat.more_levels;
      C_OUT_FREE:    taken = stat.out_free;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      step_next = cw.target;
    end else if (cw.hold) begin
      step_next = step;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bdc_datapath.sv
// ----------------------------------------------------------------------------
// bdc_datapath: point store, work store and the shared lerp unit
// Each pair of neighbors: a multiply step scales both coordinates by the
// weights, then a step shifts, adds, saturates and writes back in place.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_datapath #(
  parameter int MaxPoints = bdc_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bdc_pkg::cw_t                       cw,
  output bdc_pkg::stat_t                     stat,
  input  logic                               in_fire,
  input  logic                               opcode,
  input  logic [bdc_pkg::IDX_W-1:0]          point_index,
  input  logic signed [bdc_pkg::COORD_W-1:0] point_x,
  input  logic signed [bdc_pkg::COORD_W-1:0] point_y,
  input  logic [bdc_pkg::T_W-1:0]            t,
  input  logic                               cfg_wen,
  input  logic [bdc_pkg::CNT_W-1:0]          cfg_wdata,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [bdc_pkg::COORD_W-1:0] curve_x,
  output logic signed [bdc_pkg::COORD_W-1:0] curve_y
);
  import bdc_pkg::*;

  localparam int AW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxPoints + 1);
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;
  localparam int SW = PROD_W - FRAC_W + 1;

  // shift, add and clamp to the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat_sum(
    input logic signed [PROD_W-1:0] pa,
    input logic signed [PROD_W-1:0] pb
  );
    logic signed [SW-2:0] sa;
    logic signed [SW-2:0] sb;
    logic signed [SW-1:0] s;
    sa = pa[PROD_W-1:FRAC_W];
    sb = pb[PROD_W-1:FRAC_W];
    s  = SW'(sa) + SW'(sb);
    if (s[SW-1:COORD_W-1] != {(SW-COORD_W+1){s[SW-1]}}) begin
      return s[SW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return s[COORD_W-1:0];
  endfunction

  logic signed [COORD_W-1:0] pt_x [MaxPoints];
  logic signed [COORD_W-1:0] pt_y [MaxPoints];
  logic signed [COORD_W-1:0] wk_x [MaxPoints];
  logic signed [COORD_W-1:0] wk_y [MaxPoints];

  logic [CNT_W-1:0]          point_count;
  logic [CW-1:0]             len;
  logic [CW-1:0]             idx;
  logic                      src_work;
  logic [T_W-1:0]            w1;
  logic signed [COORD_W-1:0] pt_rd_x, pt_rd_y, wk_rd_x, wk_rd_y;
  logic signed [COORD_W-1:0] a_x, a_y;
  logic signed [PROD_W-1:0]  p0_x, p1_x, p0_y, p1_y;

  logic [T_W-1:0]            w0;
  logic [T_W-1:0]            t_clamp;
  logic [CW-1:0]             n_clamp;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic [CW:0]               addr_wide;
  logic [AW-1:0]             rd_addr;
  logic                      rd_go;
  logic [XW-1:0]             ld_ext;
  logic                      ld_go;
  logic                      start;
  logic                      out_go;

  assign w0      = T_ONE - w1;
  assign t_clamp = (t > T_ONE) ? T_ONE : t;
  assign n_clamp = (32'(point_count) > 32'(MaxPoints)) ? CW'(MaxPoints) : CW'(point_count);
  assign rd_x    = src_work ? wk_rd_x : pt_rd_x;
  assign rd_y    = src_work ? wk_rd_y : pt_rd_y;
  assign start   = in_fire && (opcode == OP_SAMPLE);
  assign ld_ext  = XW'(point_index);
  assign ld_go   = in_fire && (opcode == OP_LOAD) && (32'(point_index) < 32'(MaxPoints));

  assign stat.start       = start;
  assign stat.out_free    = !out_valid || !out_stall;
  assign stat.len_zero    = (len == '0);
  assign stat.len_one     = (len == CW'(1));
  assign stat.more_pairs  = ((CW + 1)'(idx) + (CW + 1)'(2)) < (CW + 1)'(len);
  assign stat.more_levels = (len != CW'(2));

  assign out_go = cw.out_ld && stat.out_free;

  always_comb begin
    case (cw.addr_sel)
      ADDR_ZERO: addr_wide = '0;
      ADDR_IDX1: addr_wide = (CW + 1)'(idx) + (CW + 1)'(1);
      ADDR_IDX2: addr_wide = (CW + 1)'(idx) + (CW + 1)'(2);
      default:   addr_wide = '0;
    endcase
  end

  assign rd_addr = addr_wide[AW-1:0];
  // skip the look-ahead read past the last pair of a level
  assign rd_go   = cw.rd_en && ((cw.addr_sel != ADDR_IDX2) || stat.more_pairs);

  // point store: loads write, the first level and single-point samples read
  always_ff @(posedge clk) begin
    if (ld_go) begin
      pt_x[ld_ext[AW-1:0]] <= point_x;
      pt_y[ld_ext[AW-1:0]] <= point_y;
    end
    if (rd_go) begin
      pt_rd_x <= pt_x[rd_addr];
      pt_rd_y <= pt_y[rd_addr];
    end
  end

  // work store: interpolated points, overwritten in place
  always_ff @(posedge clk) begin
    if (cw.wr_en) begin
      wk_x[idx[AW-1:0]] <= sat_sum(p0_x, p1_x);
      wk_y[idx[AW-1:0]] <= sat_sum(p0_y, p1_y);
    end
    if (rd_go) begin
      wk_rd_x <= wk_x[rd_addr];
      wk_rd_y <= wk_y[rd_addr];
    end
  end

  // lerp operands and products
  always_ff @(posedge clk) begin
    if (cw.a_ld) begin
      a_x <= rd_x;
      a_y <= rd_y;
    end
    if (cw.mul_en) begin
      p0_x <= $signed({1'b0, w0}) * a_x;
      p1_x <= $signed({1'b0, w1}) * rd_x;
      p0_y <= $signed({1'b0, w0}) * a_y;
      p1_y <= $signed({1'b0, w1}) * rd_y;
    end
    if (start) begin
      w1 <= t_clamp;
    end
  end

  // counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      len         <= '0;
      idx         <= '0;
      src_work    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        point_count <= cfg_wdata;
      end
      if (start) begin
        len      <= n_clamp;
        idx      <= '0;
        src_work <= 1'b0;
      end else if (cw.lvl_dec) begin
        len      <= len - CW'(1);
        idx      <= '0;
        src_work <= 1'b1;
      end else if (cw.idx_inc) begin
        idx <= idx + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_go) begin
      curve_x <= cw.out_zero ? '0 : rd_x;
      curve_y <= cw.out_zero ? '0 : rd_y;
    end
  end

endmodule

`default_nettype wire

// File: test/bezier_ledger_pkg.sv
// ----------------------------------------------------------------------------
// bezier_ledger_pkg: curve point predictor and in-order checker
// Keeps its own copy of the control points and the point count, works out
// the curve point of every sample beat and checks results in arrival order.
// ----------------------------------------------------------------------------
package bezier_ledger_pkg;
  import bdc_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } curve_pt_t;

  localparam longint SAT_HI     = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO     = -64'sh0000_0000_8000_0000;
  localparam int     REPORT_MAX = 10;

  class bezier_ledger;
    curve_pt_t        ctrl_pts[MAX_POINTS_DEF];
    logic [CNT_W-1:0] count_reg;
    curve_pt_t        curve_due[$];
    int               checked;
    int               mismatches;

    function new();
      count_reg  = '0;
      checked    = 0;
      mismatches = 0;
      foreach (ctrl_pts[i]) begin
        ctrl_pts[i].x = '0;
        ctrl_pts[i].y = '0;
      end
    endfunction

    function void set_count(input logic [CNT_W-1:0] v);
      count_reg = v;
    endfunction

    function int pending();
      return curve_due.size();
    endfunction

    // Weighted sum of two coordinates; each product floors, the sum saturates.
    function logic signed [COORD_W-1:0] blend(input logic signed [COORD_W-1:0] a,
                                              input logic signed [COORD_W-1:0] b,
                                              input longint w0, input longint w1);
      longint s;
      s = ((w0 * longint'(a)) >>> FRAC_W) + ((w1 * longint'(b)) >>> FRAC_W);
      if (s > SAT_HI) s = SAT_HI;
      else if (s < SAT_LO) s = SAT_LO;
      return s[COORD_W-1:0];
    endfunction

    // Note one accepted input beat: a load updates the points, a sample
    // queues the curve point it must produce.
    function void note_beat(input logic op, input logic [IDX_W-1:0] idx,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic [T_W-1:0] tv);
      curve_pt_t work[MAX_POINTS_DEF];
      curve_pt_t res;
      int        n;
      longint    w0;
      longint    w1;
      if (op == OP_LOAD) begin
        if (int'(idx) < MAX_POINTS_DEF) begin
          ctrl_pts[idx].x = x;
          ctrl_pts[idx].y = y;
        end
        return;
      end
      n  = (int'(count_reg) > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(count_reg);
      w1 = (tv > T_ONE) ? longint'(T_ONE) : longint'(tv);
      w0 = longint'(T_ONE) - w1;
      res.x = '0;
      res.y = '0;
      if (n > 0) begin
        for (int i = 0; i < n; i++) work[i] = ctrl_pts[i];
        for (int len = n; len > 1; len--) begin
          for (int i = 0; i + 1 < len; i++) begin
            work[i].x = blend(work[i].x, work[i+1].x, w0, w1);
            work[i].y = blend(work[i].y, work[i+1].y, w0, w1);
          end
        end
        res = work[0];
      end
      curve_due.insert(curve_due.size(), res);
    endfunction

    function void check_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
      curve_pt_t want;
      checked++;
      if (curve_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: curve point %0d arrived with none pending: x=%0d y=%0d",
                   checked, x, y);
        return;
      end
      want = curve_due.pop_front();
      if (x !== want.x || y !== want.y) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: curve point %0d: x exp %0d got %0d, y exp %0d got %0d",
                   checked, want.x, x, want.y, y);
      end
    endfunction
  endclass

endpackage

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Bezier curve evaluator
// Loads control points, sweeps the point count through its extremes and
// many random settings, and samples the curve at random and edge values of
// t. Every result beat is checked against a predicted curve point while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import bdc_pkg::*;
  import bezier_ledger_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int NUM_PHASES   = 25;
  localparam int PHASE_BEATS  = 61;
  localparam int QUIET_PHASES = 3;
  localparam int SETTLE       = 4;    // margin for a trailing load to land
  localparam int TAIL_CYCLES  = 300;  // quiet tail after the final drain
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 2000000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      opcode = OP_LOAD;
  logic [IDX_W-1:0]          point_index = '0;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic [T_W-1:0]            t = '0;
  logic                      cfg_wen = 1'b0;
  logic [CNT_W-1:0]          cfg_wdata = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] curve_x;
  logic signed [COORD_W-1:0] curve_y;

  bezier_ledger book = new();

  // Flags shared between the stimulus and the receiver process, and run counters.
  logic quiet = 1'b0;   // no idling on either side
  int   hold_asks = 0;  // long receiver hold-offs requested so far
  int   cycles = 0;
  int   beats_sent = 0;
  int   samples_sent = 0;
  int   settings_used = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bezier_de_casteljau_eval u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .point_index(point_index),
    .point_x    (point_x),
    .point_y    (point_y),
    .t          (t),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .curve_x    (curve_x),
    .curve_y    (curve_y)
  );

  // Offer one beat, with a random gap first unless quiet; hold the payload
  // until the block takes it, then note it for prediction.
  task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic [T_W-1:0] tv);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    point_index <= idx;
    point_x     <= x;
    point_y     <= y;
    t           <= tv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_beat(op, idx, x, y, tv);
    beats_sent++;
    if (op == OP_SAMPLE) samples_sent++;
  endtask

  // Drop valid and wait until every predicted curve point has come back,
  // then wait out the SETTLE margin so a trailing load has landed too.
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_count(input logic [CNT_W-1:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    book.set_count(v);
    settings_used++;
  endtask

  // Mostly full-range coordinates, with the extremes mixed in.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shFFFF_FFFF;
      4:       return COORD_W'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $urandom;
    endcase
  endfunction

  // t at zero, at one, above one (clamped by the block) and in between.
  function automatic logic [T_W-1:0] pick_t();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return T_ONE;
      2:       return T_W'($urandom_range(65537, 131071));
      default: return T_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Stimulus: directed opening, then random phases, each under one count.
  initial begin
    logic [CNT_W-1:0] cnt;
    logic             op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Empty curve straight out of reset: (0,0) whatever t and the junk fields.
    send_beat(OP_SAMPLE, IDX_W'($urandom), $urandom, $urandom, '0);
    send_beat(OP_SAMPLE, IDX_W'($urandom), $urandom, $urandom, T_ONE);

    // Fill every position, extremes first, so no later count reads an
    // unwritten point. The load ignores t, so drive junk there.
    for (int i = 0; i < MAX_POINTS_DEF; i++) begin
      case (i)
        0:       begin x = 32'sh7FFF_FFFF; y = 32'sh8000_0000; end
        1:       begin x = 32'sh8000_0000; y = 32'sh7FFF_FFFF; end
        2:       begin x = 32'sh0000_0000; y = 32'shFFFF_FFFF; end
        3:       begin x = 32'shFFFF_FFFF; y = 32'sh0000_0000; end
        15:      begin x = 32'sh8000_0000; y = 32'sh8000_0000; end
        default: begin x = $urandom;       y = $urandom;       end
      endcase
      send_beat(OP_LOAD, IDX_W'(i), x, y, T_W'($urandom));
    end

    // A single point comes back unchanged.
    drain();
    write_count(CNT_W'(1));
    send_beat(OP_SAMPLE, IDX_W'($urandom), $urandom, $urandom, pick_t());

    // Two points at both ends of t and with t above one.
    drain();
    write_count(CNT_W'(2));
    send_beat(OP_SAMPLE, IDX_W'($urandom), $urandom, $urandom, '0);
    send_beat(OP_SAMPLE, IDX_W'($urandom), $urandom, $urandom, T_ONE);
    send_beat(OP_SAMPLE, IDX_W'($urandom), $urandom, $urandom, {T_W{1'b1}});

    // Count field all ones: the block caps it at its capacity.
    drain();
    write_count({CNT_W{1'b1}});
    send_beat(OP_SAMPLE, IDX_W'($urandom), $urandom, $urandom, T_W'(32768));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       cnt = CNT_W'(MAX_POINTS_DEF);
        1:       cnt = CNT_W'(MAX_POINTS_DEF + 1);
        2:       cnt = '0;
        3:       cnt = {CNT_W{1'b1}};
        4:       cnt = CNT_W'(1);
        default: begin
          // Keep most phases short: sample time grows with the square of n.
          case ($urandom_range(0, 9))
            7, 8:    cnt = CNT_W'($urandom_range(7, 15));
            9:       cnt = CNT_W'($urandom_range(16, 31));
            default: cnt = CNT_W'($urandom_range(0, 6));
          endcase
        end
      endcase
      drain();
      if (ph >= NUM_PHASES - QUIET_PHASES) quiet = 1'b1;
      write_count(cnt);
      // Stall the receiver for a long stretch while beats keep coming,
      // so the block fills up and pushes back on its input.
      if (ph == 5 || ph == 14) hold_asks++;
      for (int k = 0; k < PHASE_BEATS; k++) begin
        // Once mid-phase, hold off sending until all results are back.
        if (ph == 8 && k == PHASE_BEATS / 2) drain();
        op = ($urandom_range(0, 9) < 6) ? OP_SAMPLE : OP_LOAD;
        send_beat(op, IDX_W'($urandom_range(0, MAX_POINTS_DEF - 1)),
                  pick_coord(), pick_coord(), pick_t());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Summary: %0d beats (%0d samples) over %0d point-count settings, %0d results checked",
             beats_sent, samples_sent, settings_used, book.checked);
    $display("Summary: %0d mismatches, %0d results still pending",
             book.mismatches, book.pending());
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: check every result beat at the edge it is taken, then pick
  // the next stall value: a requested long hold, a short burst, or none.
  initial begin
    int   hold_left;
    int   burst_left;
    int   holds_done;
    logic stall_next;
    hold_left  = 0;
    burst_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) book.check_point(curve_x, curve_y);
      if (hold_asks != holds_done) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        stall_next = 1'b1;
      end else if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 3);
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ERROR: cycle limit of %0d reached", CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule
